// File: rtl/core/decision_tree_classify_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decision-tree classifier
// Both macros expect signals named clk and rst_n in the calling module.
// ----------------------------------------------------------------------------
`ifndef DECISION_TREE_CLASSIFY_ASSERT_SVH
`define DECISION_TREE_CLASSIFY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTC_AST_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTC_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Types, codes and default sizes shared by the decision-tree classifier.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int MAX_NODES_DEF    = 1024;
  localparam int MAX_FEATURES_DEF = 256;
  localparam int MAX_CLASSES_DEF  = 16;

  // Queue depths; both must be powers of two so the pointers wrap naturally.
  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  localparam logic [4:0] CLASS_COUNT_RST = 5'd2;

  typedef enum logic [1:0] {
    ACT_WR_NODE  = 2'd0,
    ACT_WR_LEAF  = 2'd1,
    ACT_WR_FEAT  = 2'd2,
    ACT_CLASSIFY = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NODE,
    OP_LEAF,
    OP_FEAT,
    OP_CLASSIFY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [9:0]  node;
    logic        inner;
    logic [9:0]  left;
    logic [9:0]  right;
    logic [7:0]  slot;
    logic [3:0]  cls;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic        inner;
    logic [9:0]  left;
    logic [9:0]  right;
    logic [7:0]  feature;
    logic [31:0] threshold;
  } node_rec_t;

  typedef struct packed {
    logic [3:0] cls;
    logic [9:0] leaf;
    logic       err;
  } res_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_NODE,
    ES_FEAT,
    ES_SCAN,
    ES_EMIT
  } eng_state_t;

endpackage

// File: rtl/core/dtc_front.sv
// ----------------------------------------------------------------------------
// dtc_front
// Accepts input words, sorts them into commands and queues them for the
// engine. Writes that fall outside the stores become no-ops here.
// ----------------------------------------------------------------------------
module dtc_front #(
  parameter int MAX_NODES    = dtc_pkg::MAX_NODES_DEF,
  parameter int MAX_FEATURES = dtc_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES  = dtc_pkg::MAX_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_action,
  input  logic [9:0]        in_node_index,
  input  logic              in_has_children,
  input  logic [9:0]        in_left_child,
  input  logic [9:0]        in_right_child,
  input  logic [7:0]        in_feature_slot,
  input  logic [31:0]       in_threshold,
  input  logic [3:0]        in_class_index,
  input  logic [31:0]       in_class_weight,
  input  logic [31:0]       in_feature_value,
  output logic              cmd_valid,
  output dtc_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  localparam int PTR_W = (dtc_pkg::CMDQ_DEPTH > 1) ? $clog2(dtc_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(dtc_pkg::CMDQ_DEPTH + 1);

  dtc_pkg::cmd_t  q_r [dtc_pkg::CMDQ_DEPTH];
  dtc_pkg::cmd_t  dec;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;
  logic             node_ok;
  logic             cls_ok;
  logic             slot_ok;

  assign node_ok = {22'd0, in_node_index} < MAX_NODES;
  assign cls_ok  = {28'd0, in_class_index} < MAX_CLASSES;
  assign slot_ok = {24'd0, in_feature_slot} < MAX_FEATURES;

  always_comb begin
    dec.node  = in_node_index;
    dec.inner = in_has_children;
    dec.left  = in_left_child;
    dec.right = in_right_child;
    dec.slot  = in_feature_slot;
    dec.cls   = in_class_index;
    dec.op    = dtc_pkg::OP_NOP;
    dec.data  = in_threshold;
    case (dtc_pkg::action_t'(in_action))
      dtc_pkg::ACT_WR_NODE: begin
        dec.op   = node_ok ? dtc_pkg::OP_NODE : dtc_pkg::OP_NOP;
        dec.data = in_threshold;
      end
      dtc_pkg::ACT_WR_LEAF: begin
        dec.op   = (node_ok && cls_ok) ? dtc_pkg::OP_LEAF : dtc_pkg::OP_NOP;
        dec.data = in_class_weight;
      end
      dtc_pkg::ACT_WR_FEAT: begin
        dec.op   = slot_ok ? dtc_pkg::OP_FEAT : dtc_pkg::OP_NOP;
        dec.data = in_feature_value;
      end
      dtc_pkg::ACT_CLASSIFY: begin
        dec.op = dtc_pkg::OP_CLASSIFY;
      end
      default: begin
        dec.op = dtc_pkg::OP_NOP;
      end
    endcase
  end

  assign full      = (cnt_r == CNT_W'(dtc_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/core/dtc_resq.sv
// ----------------------------------------------------------------------------
// dtc_resq
// Small result queue that lets the engine finish a word while the consumer
// still holds off the previous one.
// ----------------------------------------------------------------------------
module dtc_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  dtc_pkg::res_t res,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output logic [3:0]    out_predicted_class,
  output logic [9:0]    out_reached_leaf,
  output logic          out_walk_error
);

  localparam int PTR_W = (dtc_pkg::RESQ_DEPTH > 1) ? $clog2(dtc_pkg::RESQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(dtc_pkg::RESQ_DEPTH + 1);

  dtc_pkg::res_t    q_r [dtc_pkg::RESQ_DEPTH];
  dtc_pkg::res_t    head;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign res_full = (cnt_r == CNT_W'(dtc_pkg::RESQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  assign head                = q_r[rd_ptr_r];
  assign out_predicted_class = head.cls;
  assign out_reached_leaf    = head.leaf;
  assign out_walk_error      = head.err;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

// File: rtl/core/dtc_engine.sv
// ----------------------------------------------------------------------------
// dtc_engine
// Holds the tree, leaf-weight and feature memories, performs writes and
// walks the tree for classify commands, then scans the leaf weights.
// ----------------------------------------------------------------------------
`include "decision_tree_classify_assert.svh"

module dtc_engine #(
  parameter int MAX_NODES    = dtc_pkg::MAX_NODES_DEF,
  parameter int MAX_FEATURES = dtc_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES  = dtc_pkg::MAX_CLASSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [4:0]    cfg_wr_data,
  input  logic          cmd_valid,
  input  dtc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output dtc_pkg::res_t res
);

  localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int FEAT_AW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CLS_W      = $clog2(MAX_CLASSES);
  localparam int STEP_W     = $clog2(MAX_NODES + 1);
  localparam int LEAF_DEPTH = MAX_NODES * (2 ** CLS_W);

  // Memories
  dtc_pkg::node_rec_t node_mem [MAX_NODES];
  logic [31:0]        leaf_mem [LEAF_DEPTH];
  logic [31:0]        feat_mem [MAX_FEATURES];

  dtc_pkg::node_rec_t node_q_r;
  logic [31:0]        leaf_q_r;
  logic [31:0]        feat_q_r;

  dtc_pkg::node_rec_t   node_wd;
  logic                 node_we, node_re;
  logic [NODE_AW-1:0]   node_ra;
  logic                 leaf_we, leaf_re;
  logic [NODE_AW+CLS_W-1:0] leaf_wa, leaf_ra;
  logic                 feat_we, feat_re;
  logic [FEAT_AW-1:0]   feat_wa, feat_ra;

  // Control and walk state
  dtc_pkg::eng_state_t state_r, state_nxt;
  logic [4:0]          class_count_r;
  logic [NODE_AW-1:0]  cur_r, cur_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic [CLS_W-1:0]    rcv_r, rcv_nxt;
  logic [CLS_W-1:0]    bcls_r, bcls_nxt;
  logic [31:0]         best_r, best_nxt;
  dtc_pkg::res_t       res_r, res_nxt;

  logic [CLS_W-1:0]    last_cls;
  logic                slot_ok;
  logic [31:0]         x_val;
  logic [9:0]          child;

  always_comb begin
    if (class_count_r == 5'd0) begin
      last_cls = '0;
    end else if ({27'd0, class_count_r} > MAX_CLASSES) begin
      last_cls = CLS_W'(MAX_CLASSES - 1);
    end else begin
      last_cls = CLS_W'(class_count_r - 5'd1);
    end
  end

  assign slot_ok = {24'd0, node_q_r.feature} < MAX_FEATURES;
  assign x_val   = slot_ok ? feat_q_r : 32'd0;
  assign child   = ($signed(x_val) > $signed(node_q_r.threshold)) ? node_q_r.right
                                                                  : node_q_r.left;

  assign node_wd.inner     = cmd.inner;
  assign node_wd.left      = cmd.left;
  assign node_wd.right     = cmd.right;
  assign node_wd.feature   = cmd.slot;
  assign node_wd.threshold = cmd.data;
  assign leaf_wa           = {NODE_AW'(cmd.node), CLS_W'(cmd.cls)};
  assign feat_wa           = FEAT_AW'(cmd.slot);
  assign res               = res_r;

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    node_we   = 1'b0;
    leaf_we   = 1'b0;
    feat_we   = 1'b0;
    node_re   = 1'b0;
    node_ra   = cur_r;
    feat_re   = 1'b0;
    feat_ra   = FEAT_AW'(node_q_r.feature);
    leaf_re   = 1'b0;
    leaf_ra   = {cur_r, rcv_r};
    res_push  = 1'b0;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    rcv_nxt   = rcv_r;
    bcls_nxt  = bcls_r;
    best_nxt  = best_r;
    res_nxt   = res_r;
    case (state_r)
      dtc_pkg::ES_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            dtc_pkg::OP_NODE: begin
              node_we = 1'b1;
            end
            dtc_pkg::OP_LEAF: begin
              leaf_we = 1'b1;
            end
            dtc_pkg::OP_FEAT: begin
              feat_we = 1'b1;
            end
            dtc_pkg::OP_CLASSIFY: begin
              node_re   = 1'b1;
              node_ra   = '0;
              cur_nxt   = '0;
              steps_nxt = '0;
              state_nxt = dtc_pkg::ES_NODE;
            end
            default: begin
            end
          endcase
        end
      end
      dtc_pkg::ES_NODE: begin
        if (!node_q_r.inner) begin
          leaf_re   = 1'b1;
          leaf_ra   = {cur_r, {CLS_W{1'b0}}};
          rcv_nxt   = '0;
          state_nxt = dtc_pkg::ES_SCAN;
        end else if (steps_r >= STEP_W'(MAX_NODES)) begin
          res_nxt.cls  = 4'd0;
          res_nxt.leaf = 10'd0;
          res_nxt.err  = 1'b1;
          state_nxt    = dtc_pkg::ES_EMIT;
        end else begin
          steps_nxt = steps_r + 1'b1;
          feat_re   = slot_ok;
          state_nxt = dtc_pkg::ES_FEAT;
        end
      end
      dtc_pkg::ES_FEAT: begin
        if ({22'd0, child} >= MAX_NODES) begin
          res_nxt.cls  = 4'd0;
          res_nxt.leaf = 10'd0;
          res_nxt.err  = 1'b1;
          state_nxt    = dtc_pkg::ES_EMIT;
        end else begin
          cur_nxt   = NODE_AW'(child);
          node_re   = 1'b1;
          node_ra   = NODE_AW'(child);
          state_nxt = dtc_pkg::ES_NODE;
        end
      end
      dtc_pkg::ES_SCAN: begin
        // Strict compare keeps the lowest class index on a tie.
        if (rcv_r == '0 || leaf_q_r > best_r) begin
          best_nxt = leaf_q_r;
          bcls_nxt = rcv_r;
        end
        if (rcv_r == last_cls) begin
          res_nxt.cls  = 4'(bcls_nxt);
          res_nxt.leaf = 10'(cur_r);
          res_nxt.err  = 1'b0;
          state_nxt    = dtc_pkg::ES_EMIT;
        end else begin
          leaf_re = 1'b1;
          leaf_ra = {cur_r, CLS_W'(rcv_r + 1'b1)};
          rcv_nxt = CLS_W'(rcv_r + 1'b1);
        end
      end
      dtc_pkg::ES_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = dtc_pkg::ES_IDLE;
        end
      end
      default: begin
        state_nxt = dtc_pkg::ES_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dtc_pkg::ES_IDLE;
      class_count_r <= dtc_pkg::CLASS_COUNT_RST;
      steps_r       <= '0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      if (cfg_wr_en) begin
        class_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rcv_r  <= rcv_nxt;
    bcls_r <= bcls_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[NODE_AW'(cmd.node)] <= node_wd;
    end
    if (node_re) begin
      node_q_r <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= cmd.data;
    end
    if (leaf_re) begin
      leaf_q_r <= leaf_mem[leaf_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_wa] <= cmd.data;
    end
    if (feat_re) begin
      feat_q_r <= feat_mem[feat_ra];
    end
  end

  `DTC_AST_IMPLY(a_push_room, res_push, !res_full, "result pushed into a full queue")
  `DTC_AST_IMPLY(a_err_zero, res_push && res_r.err,
                 res_r.cls == 4'd0 && res_r.leaf == 10'd0, "error word carries data")
  `DTC_AST_IMPLY(a_steps_bound, state_r != dtc_pkg::ES_IDLE,
                 steps_r <= STEP_W'(MAX_NODES), "walk step count overran")
  `DTC_AST_IMPLY(a_no_wr_walk, state_r != dtc_pkg::ES_IDLE,
                 !(node_we || leaf_we || feat_we), "store written during a walk")
  `DTC_AST_NEXT(a_walk_start, cmd_pop && cmd.op == dtc_pkg::OP_CLASSIFY,
                state_r == dtc_pkg::ES_NODE, "classify did not start a walk")

endmodule

// File: rtl/core/decision_tree_classify.sv
// Writes: a word is accepted every cycle while the command queue has room.
// Classify: the engine alternates a node memory read and a feature memory read for each
// inner node on the walk, then scans the leaf weights of the N compared classes.
// Reset (rst_n low, synchronous) empties both queues and sets class_count to 2;
// the node, weight and feature memories are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// decision_tree_classify
// Binary decision-tree classifier with a command queue, a walk engine and a
// result queue.
// ----------------------------------------------------------------------------
module decision_tree_classify #(
  parameter int MAX_NODES    = dtc_pkg::MAX_NODES_DEF,
  parameter int MAX_FEATURES = dtc_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES  = dtc_pkg::MAX_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_node_index,
  input  logic        in_has_children,
  input  logic [9:0]  in_left_child,
  input  logic [9:0]  in_right_child,
  input  logic [7:0]  in_feature_slot,
  input  logic [31:0] in_threshold,
  input  logic [3:0]  in_class_index,
  input  logic [31:0] in_class_weight,
  input  logic [31:0] in_feature_value,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_predicted_class,
  output logic [9:0]  out_reached_leaf,
  output logic        out_walk_error,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  logic          cmd_valid;
  dtc_pkg::cmd_t cmd;
  logic          cmd_pop;
  logic          res_full;
  logic          res_push;
  dtc_pkg::res_t res;

  dtc_front #(
    .MAX_NODES    (MAX_NODES),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_node_index    (in_node_index),
    .in_has_children  (in_has_children),
    .in_left_child    (in_left_child),
    .in_right_child   (in_right_child),
    .in_feature_slot  (in_feature_slot),
    .in_threshold     (in_threshold),
    .in_class_index   (in_class_index),
    .in_class_weight  (in_class_weight),
    .in_feature_value (in_feature_value),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  dtc_engine #(
    .MAX_NODES    (MAX_NODES),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  dtc_resq u_resq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_push            (res_push),
    .res                 (res),
    .res_full            (res_full),
    .empty               (empty),
    .pop                 (pop),
    .out_predicted_class (out_predicted_class),
    .out_reached_leaf    (out_reached_leaf),
    .out_walk_error      (out_walk_error)
  );

endmodule
